// ===== rtl/core/rlps_pkg.sv =====
`default_nettype none

package rlps_pkg;

    // Geometry of one pixel
    localparam int BITS_PER_COLOR = 8;
    localparam int NUM_COLORS     = 3;
    localparam int SYMS_PER_PIXEL = BITS_PER_COLOR * NUM_COLORS;
    localparam int CNT_W          = $clog2(SYMS_PER_PIXEL + 1);

    // Brightness scaling: value * pct / 100, divide done by reciprocal.
    // floor(p / 100) == (p * 41944) >> 22 for every p up to 255 * 100.
    localparam logic [6:0]  PCT_FULL  = 7'd100;
    localparam int          PROD_W    = BITS_PER_COLOR + 7;
    localparam logic [15:0] DIV_MUL   = 16'd41944;
    localparam int          DIV_SHIFT = 22;
    localparam int          QPROD_W   = PROD_W + 16;

    // Register map, byte address 4 * index
    localparam int ADDR_W = 5;
    typedef enum logic [2:0] {
        REG_BRIGHTNESS = 3'd0,
        REG_ONE_HIGH   = 3'd1,
        REG_ONE_LOW    = 3'd2,
        REG_ZERO_HIGH  = 3'd3,
        REG_ZERO_LOW   = 3'd4,
        REG_LATCH      = 3'd5
    } t_reg_idx;

    // Reset values; 13440 ticks is 280 us at 48 MHz
    localparam logic [6:0]  RST_BRIGHTNESS = 7'd100;
    localparam logic [7:0]  RST_ONE_HIGH   = 8'd40;
    localparam logic [7:0]  RST_ONE_LOW    = 8'd20;
    localparam logic [7:0]  RST_ZERO_HIGH  = 8'd20;
    localparam logic [7:0]  RST_ZERO_LOW   = 8'd40;
    localparam logic [15:0] RST_LATCH      = 16'd13440;

    typedef struct packed {
        logic [6:0]  brightness_percent;
        logic [7:0]  one_high_ticks;
        logic [7:0]  one_low_ticks;
        logic [7:0]  zero_high_ticks;
        logic [7:0]  zero_low_ticks;
        logic [15:0] latch_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0] green_in;
        logic [7:0] red_in;
        logic [7:0] blue_in;
        logic       last_pixel;
    } t_pixel;

    typedef struct packed {
        logic        bit_level;
        logic        is_latch;
        logic [7:0]  high_ticks;
        logic [15:0] low_ticks;
        logic        last_symbol;
    } t_symbol;

    // Scaled pixel handed to the serializer, GRB order, MSB first
    typedef struct packed {
        logic [SYMS_PER_PIXEL-1:0] grb;
        logic                      last;
    } t_word;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_led_pulse_serializer.sv =====
`default_nettype none

// GRB pulse serializer for addressable RGB LED strips. Each pixel request
// carries green, red and blue bytes and a last-pixel flag; every byte is
// scaled by brightness_percent / 100 (truncated, values above 100 act as
// 100) and sent as 24 bit symbols, green first, MSB first, one symbol per
// cycle unless i_sym_ready stalls the output. A pixel flagged last adds a
// latch symbol that holds the line low for latch_ticks. A new pixel loads
// on the cycle the previous one emits its final symbol, so the output
// streams without gaps. The accept edge loads the multiply stage; the
// pixel then passes the reciprocal divide, the serializer load and the
// output register before its first symbol is valid. Tick registers that
// hold zero are used as one. Registers sit at byte address 4 * index on
// the APB port and take effect immediately; write them only while the
// block is idle.
module rgb_led_pulse_serializer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_pix_valid,
    output logic                             o_pix_ready,
    input  wire rlps_pkg::t_pixel            i_pix,
    output logic                             o_sym_valid,
    input  wire logic                        i_sym_ready,
    output rlps_pkg::t_symbol                o_sym,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rlps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import rlps_pkg::*;

    t_cfg  w_cfg;
    logic  w_word_vld;
    logic  w_word_rdy;
    t_word w_word;

    rlps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rlps_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix_valid),
        .o_ready (o_pix_ready),
        .i_pix   (i_pix),
        .i_pct   (w_cfg.brightness_percent),
        .o_valid (w_word_vld),
        .i_ready (w_word_rdy),
        .o_word  (w_word)
    );

    rlps_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_word_vld),
        .o_ready (w_word_rdy),
        .i_word  (w_word),
        .i_cfg   (w_cfg),
        .o_valid (o_sym_valid),
        .i_ready (i_sym_ready),
        .o_sym   (o_sym)
    );

    // Latch symbol always closes the pixel and never drives the line high
    a_latch_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sym_valid && o_sym.is_latch |->
            o_sym.last_symbol && !o_sym.bit_level && (o_sym.high_ticks == 8'd0)
            && (o_sym.low_ticks != 16'd0))
        else $error("malformed latch symbol");

    // Data symbols always have nonzero pulse lengths
    a_data_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sym_valid && !o_sym.is_latch |->
            (o_sym.high_ticks != 8'd0) && (o_sym.low_ticks != 16'd0))
        else $error("data symbol with zero pulse length");

    // A latch symbol is never followed directly by another latch symbol
    a_no_double_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sym_valid && i_sym_ready && o_sym.is_latch |=>
            !(o_sym_valid && o_sym.is_latch))
        else $error("back to back latch symbols");

endmodule

`default_nettype wire

// ===== rtl/core/rlps_cfg.sv =====
`default_nettype none

module rlps_cfg (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [rlps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output rlps_pkg::t_cfg             o_cfg
);
    import rlps_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes; unmapped indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness_percent <= RST_BRIGHTNESS;
            r_cfg.one_high_ticks     <= RST_ONE_HIGH;
            r_cfg.one_low_ticks      <= RST_ONE_LOW;
            r_cfg.zero_high_ticks    <= RST_ZERO_HIGH;
            r_cfg.zero_low_ticks     <= RST_ZERO_LOW;
            r_cfg.latch_ticks        <= RST_LATCH;
        end else if (w_wr) begin
            case (w_idx)
                REG_BRIGHTNESS: r_cfg.brightness_percent <= pwdata[6:0];
                REG_ONE_HIGH:   r_cfg.one_high_ticks     <= pwdata[7:0];
                REG_ONE_LOW:    r_cfg.one_low_ticks      <= pwdata[7:0];
                REG_ZERO_HIGH:  r_cfg.zero_high_ticks    <= pwdata[7:0];
                REG_ZERO_LOW:   r_cfg.zero_low_ticks     <= pwdata[7:0];
                REG_LATCH:      r_cfg.latch_ticks        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (w_idx)
            REG_BRIGHTNESS: prdata = {25'd0, r_cfg.brightness_percent};
            REG_ONE_HIGH:   prdata = {24'd0, r_cfg.one_high_ticks};
            REG_ONE_LOW:    prdata = {24'd0, r_cfg.one_low_ticks};
            REG_ZERO_HIGH:  prdata = {24'd0, r_cfg.zero_high_ticks};
            REG_ZERO_LOW:   prdata = {24'd0, r_cfg.zero_low_ticks};
            REG_LATCH:      prdata = {16'd0, r_cfg.latch_ticks};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/rlps_scale.sv =====
`default_nettype none

module rlps_scale (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire rlps_pkg::t_pixel i_pix,
    input  wire logic [6:0]       i_pct,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output rlps_pkg::t_word       o_word
);
    import rlps_pkg::*;

    // Stage 1: color * pct products
    logic              r_s1_vld;
    logic [PROD_W-1:0] r_s1_prod [NUM_COLORS];
    logic              r_s1_last;
    // Stage 2: products / 100
    logic              r_s2_vld;
    t_word             r_s2_word;

    logic                      w_s1_adv;
    logic                      w_s2_adv;
    logic [6:0]                w_pct;
    logic [BITS_PER_COLOR-1:0] w_color [NUM_COLORS];
    logic [QPROD_W-1:0]        w_qprod [NUM_COLORS];
    logic [SYMS_PER_PIXEL-1:0] w_grb;

    // Stall chain: a stage moves when the next one is empty or moving
    assign w_s2_adv = !r_s2_vld || i_ready;
    assign w_s1_adv = !r_s1_vld || w_s2_adv;
    assign o_ready  = w_s1_adv;
    assign o_valid  = r_s2_vld;
    assign o_word   = r_s2_word;

    // Brightness above full scale counts as full scale
    assign w_pct = (i_pct > PCT_FULL) ? PCT_FULL : i_pct;

    assign w_color[0] = i_pix.green_in;
    assign w_color[1] = i_pix.red_in;
    assign w_color[2] = i_pix.blue_in;

    // Reciprocal multiply per lane, quotient taken from the top bits
    always_comb begin
        for (int c = 0; c < NUM_COLORS; c++) begin
            w_qprod[c] = QPROD_W'(r_s1_prod[c]) * QPROD_W'(DIV_MUL);
            w_grb[(NUM_COLORS-1-c)*BITS_PER_COLOR +: BITS_PER_COLOR] =
                w_qprod[c][DIV_SHIFT +: BITS_PER_COLOR];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_s1_adv) r_s1_vld <= i_valid;
            if (w_s2_adv) r_s2_vld <= r_s1_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            for (int c = 0; c < NUM_COLORS; c++) begin
                r_s1_prod[c] <= PROD_W'(w_color[c]) * PROD_W'(w_pct);
            end
            r_s1_last <= i_pix.last_pixel;
        end
        if (w_s2_adv) begin
            r_s2_word.grb  <= w_grb;
            r_s2_word.last <= r_s1_last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rlps_serial.sv =====
`default_nettype none

module rlps_serial (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire rlps_pkg::t_word i_word,
    input  wire rlps_pkg::t_cfg  i_cfg,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output rlps_pkg::t_symbol    o_sym
);
    import rlps_pkg::*;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(SYMS_PER_PIXEL - 1);
    localparam logic [CNT_W-1:0] LATCH_AT = CNT_W'(SYMS_PER_PIXEL);

    logic                      r_busy;
    logic [SYMS_PER_PIXEL-1:0] r_bits;
    logic                      r_last;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_out_vld;
    t_symbol                   r_out;

    logic    w_out_adv;
    logic    w_emit;
    logic    w_done;
    logic    w_take;
    logic    w_latch;
    logic    w_bit;
    t_symbol n_out;

    assign w_out_adv = !r_out_vld || i_ready;
    assign w_emit    = r_busy && w_out_adv;
    assign w_latch   = (r_cnt == LATCH_AT);
    assign w_done    = w_latch || ((r_cnt == LAST_BIT) && !r_last);
    // New word loads in the cycle the previous one emits its final symbol
    assign w_take    = !r_busy || (w_emit && w_done);
    assign o_ready   = w_take;
    assign o_valid   = r_out_vld;
    assign o_sym     = r_out;
    assign w_bit     = r_bits[SYMS_PER_PIXEL-1];

    // Symbol for the current count; zero tick settings count as one
    always_comb begin
        n_out.last_symbol = w_done;
        if (w_latch) begin
            n_out.bit_level  = 1'b0;
            n_out.is_latch   = 1'b1;
            n_out.high_ticks = 8'd0;
            n_out.low_ticks  = (i_cfg.latch_ticks == 16'd0) ? 16'd1 : i_cfg.latch_ticks;
        end else if (w_bit) begin
            n_out.bit_level  = 1'b1;
            n_out.is_latch   = 1'b0;
            n_out.high_ticks = (i_cfg.one_high_ticks == 8'd0) ? 8'd1 : i_cfg.one_high_ticks;
            n_out.low_ticks  = (i_cfg.one_low_ticks == 8'd0) ? 16'd1
                                                              : {8'd0, i_cfg.one_low_ticks};
        end else begin
            n_out.bit_level  = 1'b0;
            n_out.is_latch   = 1'b0;
            n_out.high_ticks = (i_cfg.zero_high_ticks == 8'd0) ? 8'd1
                                                                : i_cfg.zero_high_ticks;
            n_out.low_ticks  = (i_cfg.zero_low_ticks == 8'd0) ? 16'd1
                                                               : {8'd0, i_cfg.zero_low_ticks};
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_out_adv) r_out_vld <= r_busy;
            if (w_take) begin
                r_busy <= i_valid;
                r_cnt  <= '0;
            end else if (w_emit) begin
                r_cnt  <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Shift register and output register
    always_ff @(posedge i_clk) begin
        if (w_take && i_valid) begin
            r_bits <= i_word.grb;
            r_last <= i_word.last;
        end else if (w_emit) begin
            r_bits <= {r_bits[SYMS_PER_PIXEL-2:0], 1'b0};
        end
        if (w_emit) r_out <= n_out;
    end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rlps_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          SETTLE_TICKS = 12;
    localparam int          RAND_PHASES  = 6;
    localparam int          RAND_PER_PH  = 30;
    localparam int          REPORT_CAP   = 40;
    // addresses past the register map, writes there must be dropped
    localparam logic [2:0]  REG_SPARE_6  = 3'd6;
    localparam logic [2:0]  REG_SPARE_7  = 3'd7;

    // DUT connections
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_pix_valid = 1'b0;
    logic                o_pix_ready;
    t_pixel              i_pix       = '0;
    logic                o_sym_valid;
    logic                i_sym_ready = 1'b0;
    t_symbol             o_sym;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    // testbench state
    t_cfg                cfg_shadow;
    t_pixel              pix_q[$];
    t_symbol             sym_expect_q[$];
    int                  err_count   = 0;
    int                  sym_count   = 0;
    int                  cycle_count = 0;
    int                  src_gap     = 0;
    int                  snk_stall   = 0;
    int                  hold_cnt    = 0;
    logic                hold_start  = 1'b0;
    logic                src_gaps_on = 1'b1;
    logic                snk_gaps_on = 1'b1;

    rgb_led_pulse_serializer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pix       (i_pix),
        .o_sym_valid (o_sym_valid),
        .i_sym_ready (i_sym_ready),
        .o_sym       (o_sym),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Pulse encoder prediction
    // ---------------------------------------------------------------
    function automatic logic [15:0] tick_floor(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic logic [7:0] scale_byte(input logic [7:0] v, input logic [6:0] pct);
        int unsigned p;
        p = (pct > PCT_FULL) ? PCT_FULL : pct;
        return 8'((v * p) / PCT_FULL);
    endfunction

    // 24 data symbols GRB, MSB first, latch symbol on the last pixel
    task automatic encode_pixel(input t_pixel px);
        logic [SYMS_PER_PIXEL-1:0] grb;
        t_symbol                   s;
        grb = {scale_byte(px.green_in, cfg_shadow.brightness_percent),
               scale_byte(px.red_in,   cfg_shadow.brightness_percent),
               scale_byte(px.blue_in,  cfg_shadow.brightness_percent)};
        for (int k = 0; k < SYMS_PER_PIXEL; k++) begin
            s.bit_level   = grb[SYMS_PER_PIXEL-1-k];
            s.is_latch    = 1'b0;
            s.high_ticks  = s.bit_level ? 8'(tick_floor({8'd0, cfg_shadow.one_high_ticks}))
                                        : 8'(tick_floor({8'd0, cfg_shadow.zero_high_ticks}));
            s.low_ticks   = s.bit_level ? tick_floor({8'd0, cfg_shadow.one_low_ticks})
                                        : tick_floor({8'd0, cfg_shadow.zero_low_ticks});
            s.last_symbol = !px.last_pixel && (k == SYMS_PER_PIXEL - 1);
            sym_expect_q.push_back(s);
        end
        if (px.last_pixel) begin
            s.bit_level   = 1'b0;
            s.is_latch    = 1'b1;
            s.high_ticks  = 8'd0;
            s.low_ticks   = tick_floor(cfg_shadow.latch_ticks);
            s.last_symbol = 1'b1;
            sym_expect_q.push_back(s);
        end
    endtask

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (err_count < REPORT_CAP)
            $display("[%0t] symbol %0d: %s got %0d want %0d", $time, sym_count, what, got, want);
        err_count++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_tick();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // sometimes sets junk above the register width
    function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
        logic [31:0] junk;
        junk = $urandom;
        if ($urandom_range(0, 3) == 0)
            return (junk << w) | v;
        return v;
    endfunction

    // APB write: setup, then access; register loads on the access edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_BRIGHTNESS: cfg_shadow.brightness_percent = data[6:0];
            REG_ONE_HIGH:   cfg_shadow.one_high_ticks     = data[7:0];
            REG_ONE_LOW:    cfg_shadow.one_low_ticks      = data[7:0];
            REG_ZERO_HIGH:  cfg_shadow.zero_high_ticks    = data[7:0];
            REG_ZERO_LOW:   cfg_shadow.zero_low_ticks     = data[7:0];
            REG_LATCH:      cfg_shadow.latch_ticks        = data[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic config_all(input logic [6:0] bri, input logic [7:0] oh, input logic [7:0] ol,
                              input logic [7:0] zh, input logic [7:0] zl,
                              input logic [15:0] lat);
        write_reg(REG_BRIGHTNESS, with_junk({25'd0, bri}, 7));
        write_reg(REG_ONE_HIGH,   with_junk({24'd0, oh}, 8));
        write_reg(REG_ONE_LOW,    with_junk({24'd0, ol}, 8));
        write_reg(REG_ZERO_HIGH,  with_junk({24'd0, zh}, 8));
        write_reg(REG_ZERO_LOW,   with_junk({24'd0, zl}, 8));
        write_reg(REG_LATCH,      with_junk({16'd0, lat}, 16));
        @(negedge i_clk);
    endtask

    task automatic add_pixel(input logic [7:0] g, input logic [7:0] r, input logic [7:0] b,
                             input logic last);
        t_pixel px;
        px.green_in   = g;
        px.red_in     = r;
        px.blue_in    = b;
        px.last_pixel = last;
        pix_q.push_back(px);
    endtask

    // wait until every request is sent and every symbol is back
    task automatic drain();
        do @(negedge i_clk);
        while (pix_q.size() != 0 || i_pix_valid || sym_expect_q.size() != 0);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Pixel driver
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pix_valid <= 1'b0;
            i_pix       <= '0;
            src_gap     = 0;
        end else begin
            if (i_pix_valid && o_pix_ready) begin
                encode_pixel(i_pix);
                if (src_gaps_on)
                    src_gap = pick_gap();
            end
            // slot is free when idle or the request just went through
            if (!i_pix_valid || o_pix_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_pix_valid <= 1'b0;
                end else if (pix_q.size() != 0) begin
                    i_pix_valid <= 1'b1;
                    i_pix       <= pix_q.pop_front();
                end else begin
                    i_pix_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Symbol sink: random stalls, plus the long hold-off
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_cnt <= 0;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_start)
            hold_cnt <= HOLD_CYCLES;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_sym_ready <= 1'b0;
            snk_stall   = 0;
        end else if (hold_cnt != 0) begin
            i_sym_ready <= 1'b0;
        end else if (snk_stall > 0) begin
            snk_stall--;
            i_sym_ready <= 1'b0;
        end else begin
            i_sym_ready <= 1'b1;
            if (snk_gaps_on && $urandom_range(0, 5) == 0)
                snk_stall = pick_gap();
        end
    end

    // ---------------------------------------------------------------
    // Symbol monitor
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_symbol want;
        if (i_rst_n && o_sym_valid && i_sym_ready) begin
            if (sym_expect_q.size() == 0) begin
                report_mismatch("unexpected symbol, raw", o_sym, 0);
            end else begin
                want = sym_expect_q.pop_front();
                if (o_sym.bit_level !== want.bit_level)
                    report_mismatch("bit_level", o_sym.bit_level, want.bit_level);
                if (o_sym.is_latch !== want.is_latch)
                    report_mismatch("is_latch", o_sym.is_latch, want.is_latch);
                if (o_sym.high_ticks !== want.high_ticks)
                    report_mismatch("high_ticks", o_sym.high_ticks, want.high_ticks);
                if (o_sym.low_ticks !== want.low_ticks)
                    report_mismatch("low_ticks", o_sym.low_ticks, want.low_ticks);
                if (o_sym.last_symbol !== want.last_symbol)
                    report_mismatch("last_symbol", o_sym.last_symbol, want.last_symbol);
            end
            sym_count++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("rgb_led_pulse_serializer verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus sequence
    // ---------------------------------------------------------------
    initial begin
        cfg_shadow.brightness_percent = RST_BRIGHTNESS;
        cfg_shadow.one_high_ticks     = RST_ONE_HIGH;
        cfg_shadow.one_low_ticks      = RST_ONE_LOW;
        cfg_shadow.zero_high_ticks    = RST_ZERO_HIGH;
        cfg_shadow.zero_low_ticks     = RST_ZERO_LOW;
        cfg_shadow.latch_ticks        = RST_LATCH;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset timings: zeros, full bytes, mixed bits, with and without latch
        add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        add_pixel(8'h80, 8'h01, 8'hAA, 1'b0);
        add_pixel(8'h55, 8'hC3, 8'h7E, 1'b1);
        drain();

        // brightness zero, widest pulses and latch
        config_all(7'd0, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        add_pixel(8'h12, 8'h34, 8'h56, 1'b0);
        drain();

        // brightness at register max clamps to full; zero ticks act as one
        config_all(7'd127, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_7, 32'h0000_0001);
        @(negedge i_clk);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pixel(8'hF0, 8'h0F, 8'h99, 1'b1);
        add_pixel(8'h00, 8'hFF, 8'h00, 1'b1);
        drain();

        // narrowest nonzero settings
        config_all(7'd1, 8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        add_pixel(8'h64, 8'hC8, 8'hFE, 1'b0);
        drain();

        // just above full scale, then just below, then half
        config_all(7'd101, 8'd7, 8'd200, 8'd128, 8'd3, 16'd13440);
        add_pixel(8'hFF, 8'h7F, 8'h01, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        drain();
        config_all(7'd99, 8'd40, 8'd20, 8'd20, 8'd40, 16'h8000);
        add_pixel(8'hFF, 8'h65, 8'h64, 1'b1);
        add_pixel(8'h01, 8'h02, 8'h03, 1'b0);
        drain();
        config_all(7'd50, 8'd90, 8'd30, 8'd15, 8'd75, 16'd300);
        add_pixel(8'hFF, 8'hC9, 8'h03, 1'b0);
        add_pixel(8'hAB, 8'hCD, 8'hEF, 1'b1);
        drain();

        // random phases; one with no idling, one with the long sink hold-off
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0:       config_all(7'd0, rand_tick(), rand_tick(), rand_tick(), rand_tick(),
                                    16'($urandom_range(0, 65535)));
                1:       config_all(7'd100, rand_tick(), rand_tick(), rand_tick(), rand_tick(),
                                    16'hFFFF);
                2:       config_all(7'd127, rand_tick(), rand_tick(), rand_tick(), rand_tick(),
                                    16'd0);
                default: config_all(7'($urandom_range(0, 127)), rand_tick(), rand_tick(),
                                    rand_tick(), rand_tick(), 16'($urandom_range(1, 65535)));
            endcase
            src_gaps_on = (ph != 1) && (ph != 2);
            snk_gaps_on = (ph != 1);
            for (int n = 0; n < RAND_PER_PH; n++)
                add_pixel(rand_byte(), rand_byte(), rand_byte(), $urandom_range(0, 3) == 0);
            if (ph == 2) begin
                hold_start = 1'b1;
                @(negedge i_clk);
                hold_start = 1'b0;
            end
            drain();
        end
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;

        if (err_count == 0)
            $display("rgb_led_pulse_serializer verification clean");
        else
            $display("rgb_led_pulse_serializer verification failed");
        $finish;
    end

endmodule
